@@ rtl/core/rrbm_pkg.sv @@
// shared constants, types and helpers for the rom/ram bank mapper
`default_nettype none
package rrbm_pkg;

	// sizing of the cartridge stores
	localparam int ROM_BANKS      = 32;
	localparam int RAM_BANKS      = 4;
	localparam int ROM_BANK_BYTES = 16384;
	localparam int RAM_BANK_BYTES = 8192;

	localparam int ROM_DEPTH  = ROM_BANKS * ROM_BANK_BYTES;
	localparam int RAM_DEPTH  = RAM_BANKS * RAM_BANK_BYTES;
	localparam int ROM_ADDR_W = $clog2(ROM_DEPTH);
	localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);

	localparam logic [2:0] RAM_BANKS_L = 3'(RAM_BANKS);

	// field widths
	localparam int DATA_W     = 8;
	localparam int BUS_ADDR_W = 16;
	localparam int ROM_OFF_W  = 19;
	localparam int BANK_NUM_W = 5;

	// cartridge type codes that turn on bank control
	localparam logic [7:0] CART_MBC_FIRST = 8'd1;
	localparam logic [7:0] CART_MBC_LAST  = 8'd3;

	// ram size codes
	localparam logic [2:0] RAM_CODE_ONE_BANK   = 3'd2;
	localparam logic [2:0] RAM_CODE_FOUR_FIRST = 3'd3;
	localparam logic [2:0] RAM_CODE_FOUR_LAST  = 3'd5;

	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
	localparam logic [7:0] OPEN_BUS_BYTE  = 8'hFF;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_LOAD  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [0:0] {
		CFG_CART_CODE = 1'b0,
		CFG_RAM_SIZE  = 1'b1
	} cfg_index_t;

	// 8 KiB regions of the bus, address bits 15:13
	typedef enum logic [2:0] {
		REGION_RAM_ENABLE = 3'd0,
		REGION_ROM_BANK   = 3'd1,
		REGION_RAM_BANK   = 3'd2,
		REGION_MODE       = 3'd3,
		REGION_EXT_RAM    = 3'd5
	} region_t;

	// where a read takes its byte from
	typedef enum logic [1:0] {
		SRC_ROM  = 2'd0,
		SRC_RAM  = 2'd1,
		SRC_OPEN = 2'd2
	} src_t;

	// rom bank number wrapped to the banks that exist
	function automatic logic [BANK_NUM_W-1:0] rom_wrap(input logic [BANK_NUM_W-1:0] b);
		logic [BANK_NUM_W-1:0] r;
		r = '0;
		for (int i = 0; i < (1 << BANK_NUM_W); i++) begin
			if (b == BANK_NUM_W'(i))
				r = BANK_NUM_W'(i % ROM_BANKS);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/rrbm_ram.sv @@
// generic single-port-write, registered-read ram
`default_nettype none
module rrbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

@@ rtl/core/rom_ram_bank_mapper.sv @@
// top level of the rom/ram bank mapper
`default_nettype none
// Cartridge bank controller on a 16-bit bus. Each input transaction is a bus
// read, a bus write or a rom byte load; only reads give a result transaction.
// The block takes one transaction per cycle while the output side keeps up and
// no sweep runs: register writes, ram stores and rom loads complete at the
// accepting edge, and a read launches a registered read of the rom or ram store
// at that edge; its byte then passes from the read stage into the output
// register, where it waits until the result transaction is taken. The output
// register and the read stage let the input side take one more transaction
// while a result waits. After reset the external ram is swept to zero, one byte
// per cycle, over all RAM_DEPTH bytes (32768 at the default size); in_ready
// stays low during the sweep, while configuration writes are taken at any time.
// The rom store is not cleared and must be loaded before it is read.
module rom_ram_bank_mapper (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input transactions
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      opcode,
	input  wire logic [rrbm_pkg::BUS_ADDR_W-1:0] bus_address,
	input  wire logic [rrbm_pkg::ROM_OFF_W-1:0]  rom_offset,
	input  wire logic [rrbm_pkg::DATA_W-1:0]     data_byte,
	// result transactions
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [rrbm_pkg::DATA_W-1:0]     read_data,
	// configuration writes
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [0:0]                      cfg_index,
	input  wire logic [7:0]                      cfg_data
);

	// configuration registers
	logic [7:0] cart_code_q;
	logic [2:0] ram_size_q;

	// controller registers
	logic                                 ram_enable_q;
	logic [rrbm_pkg::BANK_NUM_W-1:0]      rom_bank_q;
	logic [1:0]                           ram_sel_q;
	logic                                 mode_q;
	logic [1:0]                           active_bank_q;

	// ram clearing sweep after reset
	logic                                 clr_q;
	logic [rrbm_pkg::RAM_ADDR_W-1:0]      clr_addr_q;

	// read stage and output register
	logic                                 valid_s1;
	rrbm_pkg::src_t                       src_s1;
	logic                                 out_valid_q;
	logic [rrbm_pkg::DATA_W-1:0]          read_data_q;

	logic                                 out_free;
	logic                                 accept;
	logic                                 do_read;
	logic                                 do_write;
	logic                                 do_load;
	logic                                 banked;
	logic [2:0]                           reach;
	logic                                 ram_open;
	rrbm_pkg::region_t                    region;
	rrbm_pkg::src_t                       src;
	logic [rrbm_pkg::BANK_NUM_W-1:0]      rd_bank;
	logic [rrbm_pkg::ROM_ADDR_W-1:0]      rom_rd_addr;
	logic [rrbm_pkg::ROM_ADDR_W-1:0]      rom_wr_addr;
	logic [rrbm_pkg::RAM_ADDR_W-1:0]      ram_addr;
	logic                                 ram_store;
	logic                                 ram_we;
	logic [rrbm_pkg::RAM_ADDR_W-1:0]      ram_wr_addr;
	logic [rrbm_pkg::DATA_W-1:0]          ram_wr_data;
	logic [rrbm_pkg::DATA_W-1:0]          rom_rdata;
	logic [rrbm_pkg::DATA_W-1:0]          ram_rdata;

	// handshakes: the read stage drains into the output register when it is free
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !clr_q && (!valid_s1 || out_free);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	assign banked = (cart_code_q >= rrbm_pkg::CART_MBC_FIRST) &&
		(cart_code_q <= rrbm_pkg::CART_MBC_LAST);

	assign do_read  = accept && (opcode == rrbm_pkg::OP_READ);
	assign do_write = accept && (opcode == rrbm_pkg::OP_WRITE) && banked;
	assign do_load  = accept && (opcode == rrbm_pkg::OP_LOAD);

	assign region = rrbm_pkg::region_t'(bus_address[15:13]);

	// number of ram banks the size code makes reachable
	always_comb begin
		if (ram_size_q == rrbm_pkg::RAM_CODE_ONE_BANK)
			reach = 3'd1;
		else if (ram_size_q >= rrbm_pkg::RAM_CODE_FOUR_FIRST &&
			ram_size_q <= rrbm_pkg::RAM_CODE_FOUR_LAST)
			reach = 3'd4;
		else
			reach = 3'd0;
	end

	// ram window is open only for an enabled, present bank on a banked cartridge
	assign ram_open = banked && ram_enable_q &&
		({1'b0, active_bank_q} < reach) &&
		({1'b0, active_bank_q} < rrbm_pkg::RAM_BANKS_L);

	// a present bank is below RAM_BANKS, so the truncation never drops bank bits
	assign ram_addr = rrbm_pkg::RAM_ADDR_W'({active_bank_q, bus_address[12:0]});

	// bank 0 below 0x4000; unbanked cartridges map the bus address straight through
	assign rd_bank = (bus_address[15:14] == 2'b00 || !banked) ?
		{3'b000, bus_address[15:14]} : rom_bank_q;
	assign rom_rd_addr = rrbm_pkg::ROM_ADDR_W'(
		{rrbm_pkg::rom_wrap(rd_bank), bus_address[13:0]});
	assign rom_wr_addr = rrbm_pkg::ROM_ADDR_W'(
		{rrbm_pkg::rom_wrap(rom_offset[18:14]), rom_offset[13:0]});

	// source of the byte for a read
	always_comb begin
		if (!bus_address[15])
			src = rrbm_pkg::SRC_ROM;
		else if (region == rrbm_pkg::REGION_EXT_RAM && ram_open)
			src = rrbm_pkg::SRC_RAM;
		else
			src = rrbm_pkg::SRC_OPEN;
	end

	// ram write port is shared between the clearing sweep and bus stores
	assign ram_store   = do_write && (region == rrbm_pkg::REGION_EXT_RAM) && ram_open;
	assign ram_we      = clr_q || ram_store;
	assign ram_wr_addr = clr_q ? clr_addr_q : ram_addr;
	assign ram_wr_data = clr_q ? '0 : data_byte;

	rrbm_ram #(
		.WIDTH(rrbm_pkg::DATA_W),
		.DEPTH(rrbm_pkg::ROM_DEPTH)
	) u_rom (
		.clk    (clk),
		.we     (do_load),
		.wr_addr(rom_wr_addr),
		.wr_data(data_byte),
		.rd_en  (do_read),
		.rd_addr(rom_rd_addr),
		.rd_data(rom_rdata)
	);

	rrbm_ram #(
		.WIDTH(rrbm_pkg::DATA_W),
		.DEPTH(rrbm_pkg::RAM_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (do_read),
		.rd_addr(ram_addr),
		.rd_data(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_code_q <= '0;
			ram_size_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rrbm_pkg::CFG_CART_CODE: cart_code_q <= cfg_data;
				rrbm_pkg::CFG_RAM_SIZE:  ram_size_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// controller registers, written by bus writes on banked cartridges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enable_q  <= 1'b0;
			rom_bank_q    <= rrbm_pkg::BANK_NUM_W'(1);
			ram_sel_q     <= '0;
			mode_q        <= 1'b0;
			active_bank_q <= '0;
		end else if (do_write) begin
			case (region)
				rrbm_pkg::REGION_RAM_ENABLE: begin
					ram_enable_q <= (data_byte[3:0] == rrbm_pkg::RAM_ENABLE_KEY);
				end
				rrbm_pkg::REGION_ROM_BANK: begin
					// bank 0 selects bank 1
					if (data_byte[4:0] == 5'd0)
						rom_bank_q <= rrbm_pkg::BANK_NUM_W'(1);
					else
						rom_bank_q <= data_byte[4:0];
				end
				rrbm_pkg::REGION_RAM_BANK: begin
					ram_sel_q <= data_byte[1:0];
					if (mode_q)
						active_bank_q <= data_byte[1:0];
				end
				rrbm_pkg::REGION_MODE: begin
					mode_q <= data_byte[0];
					if (data_byte[0])
						active_bank_q <= ram_sel_q;
				end
				default: ;
			endcase
		end
	end

	// clearing sweep of the ram store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == rrbm_pkg::RAM_ADDR_W'(rrbm_pkg::RAM_DEPTH - 1))
				clr_q <= 1'b0;
		end
	end

	// read stage: memory data arrives here in the cycle after the accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || out_free) begin
			valid_s1 <= do_read;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read)
			src_s1 <= src;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && out_free) begin
			case (src_s1)
				rrbm_pkg::SRC_ROM:  read_data_q <= rom_rdata;
				rrbm_pkg::SRC_RAM:  read_data_q <= ram_rdata;
				default:            read_data_q <= rrbm_pkg::OPEN_BUS_BYTE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule
`default_nettype wire

@@ rtl/core/rrbm_checker.sv @@
// port-level checker for the rom/ram bank mapper, with its bind
`default_nettype none
module rrbm_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic [1:0]                      opcode,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [rrbm_pkg::DATA_W-1:0]     read_data
);

	// reads accepted whose result transaction is not yet taken
	logic [1:0] pending_q;
	logic       rd_acc;
	logic       res_acc;

	assign rd_acc  = in_valid && in_ready && (opcode == rrbm_pkg::OP_READ);
	assign res_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({rd_acc, res_acc})
				2'b10:   pending_q <= pending_q + 1'b1;
				2'b01:   pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	// a held result keeps its byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data))
		else $error("result changed while stalled");

	// no result without an outstanding read
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result without a pending read");

	// at most two reads in flight: read stage and output register
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more reads in flight than stages");

	// ram sweep holds off input right after reset
	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_ready)
		else $error("input accepted during ram sweep");

endmodule

bind rom_ram_bank_mapper rrbm_checker u_rrbm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.opcode   (opcode),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.read_data(read_data)
);
`default_nettype wire
